[hw/rtl/two_point_distance_measure_defines.svh]
// assertion macros for the two point distance measure block
// expects clk and rst in the scope of each use
`ifndef TWO_POINT_DISTANCE_MEASURE_DEFINES_SVH
`define TWO_POINT_DISTANCE_MEASURE_DEFINES_SVH

// same-cycle implication
`define TPDM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpdm assertion failed");

// next-cycle implication
`define TPDM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpdm assertion failed");

`endif

[hw/rtl/tpdm_pkg.sv]
// shared types, widths and codes for the two point distance measure block
// no dependencies
package tpdm_pkg;

  localparam int COORD_BITS = 18;
  localparam int BTN_BITS   = 16;
  localparam int DIAG_BITS  = COORD_BITS + 1;
  localparam int INCH_BITS  = COORD_BITS - 1;
  localparam int SUM_BITS   = 2 * DIAG_BITS;
  localparam int REM_BITS   = DIAG_BITS + 1;
  localparam int ITER_BITS  = $clog2(DIAG_BITS);

  // cm to inch: (d * 25801) >> 16
  localparam int INCH_MUL   = 25801;
  localparam int INCH_SHIFT = 16;
  localparam int K_BITS     = 15;
  localparam int MB_BITS    = (DIAG_BITS > K_BITS) ? DIAG_BITS : K_BITS;
  localparam int PROD_BITS  = DIAG_BITS + MB_BITS;

  localparam logic KIND_ARM    = 1'b0;
  localparam logic KIND_PACKET = 1'b1;

  // measurement phase
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PRESS   = 2'd1;
  localparam logic [1:0] PH_RELEASE = 2'd2;

  // datapath operations
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_SQX  = 4'd1;
  localparam logic [3:0] OP_SQY  = 4'd2;
  localparam logic [3:0] OP_ADD  = 4'd3;
  localparam logic [3:0] OP_ROOT = 4'd4;
  localparam logic [3:0] OP_RND  = 4'd5;
  localparam logic [3:0] OP_INH  = 4'd6;
  localparam logic [3:0] OP_INV  = 4'd7;
  localparam logic [3:0] OP_IND  = 4'd8;
  localparam logic [3:0] OP_OUT  = 4'd9;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [BTN_BITS-1:0]   buttons;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] horiz_cm;
    logic [COORD_BITS-1:0] vert_cm;
    logic [DIAG_BITS-1:0]  diag_cm;
    logic [INCH_BITS-1:0]  horiz_in;
    logic [INCH_BITS-1:0]  vert_in;
    logic [COORD_BITS-1:0] diag_in;
  } out_item_t;

  typedef struct packed {
    logic       first_ld;
    logic       diff_ld;
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic root_last;
  } dp_stat_t;

  typedef struct packed {
    logic [1:0] phase;
  } ctl_stat_t;

endpackage

[hw/rtl/tpdm_ctrl.sv]
// sequencer and measurement phase tracking
// depends on tpdm_pkg
module tpdm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tpdm_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tpdm_pkg::dp_cmd_t  cmd,
  input  tpdm_pkg::dp_stat_t stat,
  output tpdm_pkg::ctl_stat_t ctl
);
  import tpdm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_ADD  = 4'd3;
  localparam logic [3:0] S_ROOT = 4'd4;
  localparam logic [3:0] S_RND  = 4'd5;
  localparam logic [3:0] S_INH  = 4'd6;
  localparam logic [3:0] S_INV  = 4'd7;
  localparam logic [3:0] S_IND  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic       out_valid_next;
  logic       accept;
  logic       pressed;
  logic       out_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign pressed   = |in_data.buttons;
  assign out_free  = !out_valid || out_ready;
  assign ctl.phase = phase;

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    cmd.first_ld = 1'b0;
    cmd.diff_ld  = 1'b0;
    cmd.op       = OP_NONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.kind == KIND_ARM) begin
            phase_next = PH_PRESS;
          end else if (phase == PH_PRESS && pressed) begin
            cmd.first_ld = 1'b1;
            phase_next   = PH_RELEASE;
          end else if (phase == PH_RELEASE && !pressed) begin
            cmd.diff_ld = 1'b1;
            phase_next  = PH_IDLE;
            state_next  = S_SQX;
          end
        end
      end
      S_SQX: begin
        cmd.op     = OP_SQX;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.op     = OP_SQY;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.op     = OP_ADD;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.op = OP_ROOT;
        if (stat.root_last) begin
          state_next = S_RND;
        end
      end
      S_RND: begin
        cmd.op     = OP_RND;
        state_next = S_INH;
      end
      S_INH: begin
        cmd.op     = OP_INH;
        state_next = S_INV;
      end
      S_INV: begin
        cmd.op     = OP_INV;
        state_next = S_IND;
      end
      S_IND: begin
        cmd.op     = OP_IND;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.op == OP_OUT) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[hw/rtl/tpdm_dp.sv]
// datapath: point registers, shared multiplier, bit-serial square root, result register
// depends on tpdm_pkg
module tpdm_dp (
  input  logic                clk,
  input  tpdm_pkg::in_item_t  in_data,
  input  tpdm_pkg::dp_cmd_t   cmd,
  output tpdm_pkg::dp_stat_t  stat,
  output tpdm_pkg::out_item_t out_data
);
  import tpdm_pkg::*;

  logic [COORD_BITS-1:0] first_x, first_y;
  logic [COORD_BITS-1:0] dx, dy;
  logic [COORD_BITS-1:0] dx_new, dy_new;
  logic [SUM_BITS-1:0]   acc;
  logic [PROD_BITS-1:0]  prod;
  logic [REM_BITS-1:0]   rem;
  logic [DIAG_BITS-1:0]  root;
  logic [ITER_BITS-1:0]  iter;
  logic [INCH_BITS-1:0]  hin, vin;
  out_item_t             out_reg;

  logic [DIAG_BITS-1:0]  mul_a;
  logic [MB_BITS-1:0]    mul_b;
  logic [REM_BITS+1:0]   rem_t;
  logic [REM_BITS+1:0]   trial;
  logic [REM_BITS+1:0]   rem_sub;
  logic                  take;

  assign dx_new = (in_data.pos_x > first_x) ? in_data.pos_x - first_x
                                            : first_x - in_data.pos_x;
  assign dy_new = (in_data.pos_y > first_y) ? in_data.pos_y - first_y
                                            : first_y - in_data.pos_y;

  // one shared multiplier for squares and the inch scaling
  always_comb begin
    case (cmd.op)
      OP_SQX: begin
        mul_a = DIAG_BITS'(dx);
        mul_b = MB_BITS'(dx);
      end
      OP_SQY: begin
        mul_a = DIAG_BITS'(dy);
        mul_b = MB_BITS'(dy);
      end
      OP_INH: begin
        mul_a = DIAG_BITS'(dx);
        mul_b = MB_BITS'(INCH_MUL);
      end
      OP_INV: begin
        mul_a = DIAG_BITS'(dy);
        mul_b = MB_BITS'(INCH_MUL);
      end
      OP_IND: begin
        mul_a = root;
        mul_b = MB_BITS'(INCH_MUL);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // one result bit per step: bring down two radicand bits, try root*4+1
  assign rem_t   = {rem, acc[SUM_BITS-1 -: 2]};
  assign trial   = (REM_BITS+2)'({root, 2'b01});
  assign take    = (rem_t >= trial);
  assign rem_sub = rem_t - trial;

  assign stat.root_last = (iter == ITER_BITS'(DIAG_BITS - 1));

  always_ff @(posedge clk) begin
    if (cmd.first_ld) begin
      first_x <= in_data.pos_x;
      first_y <= in_data.pos_y;
    end
    if (cmd.diff_ld) begin
      dx <= dx_new;
      dy <= dy_new;
    end
    // product holds while the result load waits for the output register
    if (cmd.op != OP_NONE) begin
      prod <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    end
    case (cmd.op)
      OP_SQY: begin
        acc <= SUM_BITS'(prod);
      end
      OP_ADD: begin
        acc  <= acc + SUM_BITS'(prod);
        rem  <= '0;
        root <= '0;
        iter <= '0;
      end
      OP_ROOT: begin
        if (take) begin
          rem  <= rem_sub[REM_BITS-1:0];
          root <= {root[DIAG_BITS-2:0], 1'b1};
        end else begin
          rem  <= rem_t[REM_BITS-1:0];
          root <= {root[DIAG_BITS-2:0], 1'b0};
        end
        acc  <= acc << 2;
        iter <= iter + 1'b1;
      end
      OP_RND: begin
        if (rem > REM_BITS'(root)) begin
          root <= root + 1'b1;
        end
      end
      OP_INV: begin
        hin <= prod[INCH_SHIFT +: INCH_BITS];
      end
      OP_IND: begin
        vin <= prod[INCH_SHIFT +: INCH_BITS];
      end
      OP_OUT: begin
        out_reg.horiz_cm <= dx;
        out_reg.vert_cm  <= dy;
        out_reg.diag_cm  <= root;
        out_reg.horiz_in <= hin;
        out_reg.vert_in  <= vin;
        out_reg.diag_in  <= prod[INCH_SHIFT +: COORD_BITS];
      end
      default: begin
      end
    endcase
  end

  assign out_data = out_reg;

endmodule

[hw/rtl/two_point_distance_measure.sv]
// channel | direction | payload          | accepted when
// in      | input     | in_data (kind, x, y, buttons) | in_valid && in_ready
// out     | output    | out_data (cm and inch distances) | out_valid && out_ready
//
// arm events, press packets and ignored packets leave the block idle, so in_ready stays high for the next item
// a release packet that ends a measurement loads the differences on its accepting edge,
// then holds in_ready low through two squares, add, 19 root steps
// (one result bit a cycle), round, three inch scalings through the shared multiplier,
// then the result load
// the result load waits while a previous result is still held in the output register
// rst is synchronous, active high; it returns the block to idle with nothing armed
// top level: sequencer tpdm_ctrl, datapath tpdm_dp; depends on tpdm_pkg and the defines header
`include "two_point_distance_measure_defines.svh"

module two_point_distance_measure (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tpdm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tpdm_pkg::out_item_t out_data
);
  import tpdm_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  ctl_stat_t ctl;

  // sequencer: phase tracking, step order, output valid
  tpdm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat),
    .ctl       (ctl)
  );

  // datapath: first point, differences, squares, root, inch scaling
  tpdm_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // an arm item never stalls the input and always waits for a press next
  `TPDM_ASSERT_NEXT(a_arm_one_cycle, in_valid && in_ready && in_data.kind == KIND_ARM, in_ready && ctl.phase == PH_PRESS)
  // a release while waiting for it starts the computation and disarms
  `TPDM_ASSERT_NEXT(a_release_starts, in_valid && in_ready && in_data.kind == KIND_PACKET && ctl.phase == PH_RELEASE && in_data.buttons == '0, !in_ready && ctl.phase == PH_IDLE)
  // the diagonal is never shorter than either side
  `TPDM_ASSERT_IMPL(a_diag_lower, out_valid, out_data.diag_cm >= out_data.horiz_cm && out_data.diag_cm >= out_data.vert_cm)
  // and never longer than both sides together
  `TPDM_ASSERT_IMPL(a_diag_upper, out_valid, out_data.diag_cm <= out_data.horiz_cm + out_data.vert_cm)

endmodule
